[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define CAT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define CAT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/cat_pkg.sv]
// Shared types, constants and arithmetic helpers of the spline evaluator.
`timescale 1ns / 1ps
`default_nettype none
package cat_pkg;

    localparam int CAT_MAX_POINTS = 64;    // point table depth
    localparam int CAT_HW = 40;            // working width of Horner values
    localparam int CAT_PW = CAT_HW + 17;   // width of one Horner product

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // One evaluation: local t and the four neighbors of each axis.
    typedef struct packed {
        logic [15:0]      u;
        logic [3:0][31:0] px;
        logic [3:0][31:0] py;
        logic [3:0][31:0] pz;
    } cat_job_t;

    // Multiply by local t and round half up back to Q16.16.
    function automatic logic signed [CAT_HW-1:0] cat_rnd(
        input logic signed [CAT_HW-1:0] h,
        input logic [15:0]              u
    );
        logic signed [CAT_PW-1:0] p;
        p = CAT_PW'(h) * CAT_PW'($signed({1'b0, u}));
        p = p + CAT_PW'(32'sd32768);
        return CAT_HW'(p >>> 16);
    endfunction

    // Halve with rounding and clamp to signed 32 bits.
    function automatic logic signed [31:0] cat_fin(input logic signed [CAT_HW-1:0] v);
        logic signed [CAT_HW-1:0] s;
        s = (v + CAT_HW'(32'sd1)) >>> 1;
        if (s > CAT_HW'(32'sh7fffffff))
        begin
            return 32'sh7fffffff;
        end
        else if (s < CAT_HW'(32'sh80000000))
        begin
            return 32'sh80000000;
        end
        return 32'(s);
    endfunction

endpackage
`default_nettype wire

[hdl/cat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read-first registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[hdl/cat_front.sv]
// Front end: accepts requests, writes the point table, fetches neighbors.
`timescale 1ns / 1ps
`default_nettype none
module cat_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              req_type,
    input  wire logic [5:0]        point_index,
    input  wire logic [31:0]       coord_x,
    input  wire logic [31:0]       coord_y,
    input  wire logic [31:0]       coord_z,
    input  wire logic [15:0]       time_frac,
    input  wire logic [6:0]        num_points,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output cat_pkg::cat_job_t      push_job
);
    import cat_pkg::*;

    localparam int AW = $clog2(CAT_MAX_POINTS);

    logic              s1_valid_reg, s1_valid_next;
    logic [15:0]       u_reg;
    logic [6:0]        n_eff;
    logic [22:0]       scaled;
    logic [6:0]        seg;
    logic [6:0]        idx [4];
    logic              accept, do_load, do_eval;
    logic [31:0]       wdata [3];
    logic [31:0]       rdata [3][4];

    // Clamp the point count into 1..CAT_MAX_POINTS
    always_comb
    begin
        n_eff = num_points;
        if (num_points == 7'd0)
        begin
            n_eff = 7'd1;
        end
        else if (32'(num_points) > CAT_MAX_POINTS)
        begin
            n_eff = 7'(CAT_MAX_POINTS);
        end
    end

    // Segment index, local t and wrapped neighbor indexes
    always_comb
    begin
        scaled = 23'(time_frac) * 23'(n_eff);
        seg    = scaled[22:16];
        idx[1] = seg;
        idx[0] = (seg == 7'd0) ? n_eff - 7'd1 : seg - 7'd1;
        idx[2] = (seg + 7'd1 == n_eff) ? 7'd0 : seg + 7'd1;
        idx[3] = (idx[2] + 7'd1 == n_eff) ? 7'd0 : idx[2] + 7'd1;
    end

    assign in_ready = !s1_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;
    assign do_load  = accept && (req_type == REQ_LOAD) && (32'(point_index) < CAT_MAX_POINTS);
    assign do_eval  = accept && (req_type == REQ_EVAL);

    assign wdata[0] = coord_x;
    assign wdata[1] = coord_y;
    assign wdata[2] = coord_z;

    // One table copy per neighbor so all four read in the same cycle
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        for (genvar k = 0; k < 4; k++)
        begin : g_copy
            cat_ram #(
                .WIDTH (32),
                .DEPTH (CAT_MAX_POINTS)
            ) u_ram (
                .clk   (clk),
                .we    (do_load),
                .waddr (AW'(point_index)),
                .wdata (wdata[a]),
                .re    (do_eval),
                .raddr (AW'(idx[k])),
                .rdata (rdata[a][k])
            );
        end
    end

    // Hold the fetched request until the queue takes it
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (do_eval)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_eval)
        begin
            u_reg <= scaled[15:0];
        end
    end

    // Pack the request for the queue
    always_comb
    begin
        push_job.u = u_reg;
        for (int k = 0; k < 4; k++)
        begin
            push_job.px[k] = rdata[0][k];
            push_job.py[k] = rdata[1][k];
            push_job.pz[k] = rdata[2][k];
        end
    end

    assign push_valid = s1_valid_reg;
endmodule
`default_nettype wire

[hdl/cat_queue.sv]
// Two-entry queue between the front end and the evaluation pipeline.
`timescale 1ns / 1ps
`default_nettype none
module cat_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  cat_pkg::cat_job_t push_job,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output cat_pkg::cat_job_t pop_job
);
    import cat_pkg::*;

    cat_job_t    mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end
endmodule
`default_nettype wire

[hdl/cat_back.sv]
// Back end: coefficient and Horner pipeline for position and tangent.
`timescale 1ns / 1ps
`default_nettype none
module cat_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         pop_valid,
    output logic              pop_ready,
    input  cat_pkg::cat_job_t pop_job,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       pos_x,
    output logic [31:0]       pos_y,
    output logic [31:0]       pos_z,
    output logic [31:0]       tangent_x,
    output logic [31:0]       tangent_y,
    output logic [31:0]       tangent_z
);
    import cat_pkg::*;

    logic                     en;
    logic                     v0_reg, v1_reg, v2_reg, out_valid_reg;
    logic [15:0]              u0_reg, u1_reg, u2_reg;
    logic [31:0]              pt [3][4];
    logic signed [CAT_HW-1:0] a_reg [3], b_reg [3], c0_reg [3], d0_reg [3];
    logic signed [CAT_HW-1:0] hp1_reg [3], ht1_reg [3], c1_reg [3], d1_reg [3];
    logic signed [CAT_HW-1:0] hp2_reg [3], d2_reg [3];
    logic signed [31:0]       tan2_reg [3], pos_reg [3], tan_reg [3];

    // Advance the whole pipeline unless the output is stalled
    assign en        = !out_valid_reg || out_ready;
    assign pop_ready = en;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            pt[0][k] = pop_job.px[k];
            pt[1][k] = pop_job.py[k];
            pt[2][k] = pop_job.pz[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= pop_valid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u0_reg <= pop_job.u;
            u1_reg <= u0_reg;
            u2_reg <= u1_reg;
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        logic signed [CAT_HW-1:0] e0, e1, e2, e3;

        assign e0 = CAT_HW'($signed(pt[g][0]));
        assign e1 = CAT_HW'($signed(pt[g][1]));
        assign e2 = CAT_HW'($signed(pt[g][2]));
        assign e3 = CAT_HW'($signed(pt[g][3]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // Doubled coefficients
                a_reg[g]  <= -e0 + 3 * e1 - 3 * e2 + e3;
                b_reg[g]  <= 2 * e0 - 5 * e1 + 4 * e2 - e3;
                c0_reg[g] <= e2 - e0;
                d0_reg[g] <= 2 * e1;
                // First Horner step for both polynomials
                hp1_reg[g] <= cat_rnd(a_reg[g], u0_reg) + b_reg[g];
                ht1_reg[g] <= cat_rnd(3 * a_reg[g], u0_reg) + 2 * b_reg[g];
                c1_reg[g]  <= c0_reg[g];
                d1_reg[g]  <= d0_reg[g];
                // Second step, tangent finishes here
                hp2_reg[g]  <= cat_rnd(hp1_reg[g], u1_reg) + c1_reg[g];
                tan2_reg[g] <= cat_fin(cat_rnd(ht1_reg[g], u1_reg) + c1_reg[g]);
                d2_reg[g]   <= d1_reg[g];
                // Last position step into the output register
                pos_reg[g] <= cat_fin(cat_rnd(hp2_reg[g], u2_reg) + d2_reg[g]);
                tan_reg[g] <= tan2_reg[g];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_reg[0];
    assign pos_y     = pos_reg[1];
    assign pos_z     = pos_reg[2];
    assign tangent_x = tan_reg[0];
    assign tangent_y = tan_reg[1];
    assign tangent_z = tan_reg[2];
endmodule
`default_nettype wire

[hdl/catmull_rom_loop_evaluator.sv]
// Top level of the closed-loop Catmull-Rom spline evaluator.
// Usage:
//   Input channel (in_valid/in_ready): a load request (req_type 0) writes
//   coord_x/y/z into slot point_index and gives no result; an evaluate request
//   (req_type 1) gives one result with position and tangent at time_frac.
//   Output channel (out_valid/out_ready) carries pos_* and tangent_*.
//   Config channel (cfg_valid/cfg_ready) writes num_points; cfg_ready is
//   always high. Write it only while no request is in flight.
// Timing:
//   One request per cycle is accepted while in_ready is high. A load lands in
//   the table at its accept edge. An evaluate result passes through the table
//   read register, the queue and the coefficient registers, then two Horner
//   stages; the third Horner step writes the output register.
//   Four table copies per axis let all neighbors be read in the same cycle.
// Reset: clears all valid state and sets num_points to 4; table contents are
//   undefined until loaded.
// Stall: a stalled receiver freezes the back pipeline; the two-entry queue and
//   the fetch register absorb requests before in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_loop_evaluator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [5:0]  point_index,
    input  wire logic [31:0] coord_x,
    input  wire logic [31:0] coord_y,
    input  wire logic [31:0] coord_z,
    input  wire logic [15:0] time_frac,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      pos_x,
    output logic [31:0]      pos_y,
    output logic [31:0]      pos_z,
    output logic [31:0]      tangent_x,
    output logic [31:0]      tangent_y,
    output logic [31:0]      tangent_z,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  num_points
);
    import cat_pkg::*;

    logic     [6:0] num_points_reg;
    logic           push_valid, push_ready, pop_valid, pop_ready;
    cat_job_t       push_job, pop_job;

    // Hold the point count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= 7'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_points_reg <= num_points;
        end
    end

    cat_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .time_frac   (time_frac),
        .num_points  (num_points_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    cat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    cat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .tangent_x (tangent_x),
        .tangent_y (tangent_y),
        .tangent_z (tangent_z)
    );
endmodule
`default_nettype wire

[hdl/cat_checker.sv]
// Port-level checker for the spline evaluator and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cat_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready
);
    // Hold a result until it is taken
    `CAT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    // No result right after reset release
    `CAT_ASSERT_ALWAYS(a_rst_empty, clk, $rose(rst_n) |-> !out_valid, "result present at reset release")
    // Pipeline depth keeps the output empty shortly after reset
    `CAT_ASSERT_ALWAYS(a_rst_latency, clk, $rose(rst_n) |=> !out_valid, "result too early after reset")
endmodule

bind catmull_rom_loop_evaluator cat_checker u_cat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
`default_nettype wire
